@@ sv/esa_pkg.sv @@
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types and constants for the encoder setpoint adjuster.
// ----------------------------------------------------------------------------
`default_nettype none

package esa_pkg;

  localparam int SP_W      = 16;
  localparam int STEP_W    = 14;
  localparam int TMO_W     = 16;
  localparam int INTV_W    = 8;
  localparam int CNT_W     = 8;
  localparam int ADJ_W     = 17;
  localparam int UPD_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = CNT_W + STEP_W + 1;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [SP_W-1:0]   INIT_SP_RST  = 16'd500;
  localparam logic [SP_W-1:0]   SP_MIN_RST   = 16'd200;
  localparam logic [SP_W-1:0]   SP_MAX_RST   = 16'd1500;
  localparam logic [STEP_W-1:0] FINE_RST     = 14'd10;
  localparam logic [STEP_W-1:0] COARSE_RST   = 14'd100;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 16'd5000;
  localparam logic [INTV_W-1:0] INTERVAL_RST = 8'd20;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 8'sh7f;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 8'sh80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_SETPOINT = 3'd0,
    REG_SETPOINT_MIN     = 3'd1,
    REG_SETPOINT_MAX     = 3'd2,
    REG_FINE_STEP        = 3'd3,
    REG_COARSE_STEP      = 3'd4,
    REG_CONFIRM_TIMEOUT  = 3'd5,
    REG_UPDATE_INTERVAL  = 3'd6,
    REG_REVERSE_DIR      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint_min;
    logic [SP_W-1:0]   setpoint_max;
    logic [STEP_W-1:0] fine_step;
    logic [STEP_W-1:0] coarse_step;
    logic [TMO_W-1:0]  confirm_timeout_ticks;
    logic [INTV_W-1:0] update_interval_ticks;
    logic              reverse_direction;
  } cfg_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic confirm_pulse;
    logic reset_pulse;
    logic toggle_pulse;
  } item_t;

  typedef struct packed {
    logic [SP_W-1:0] setpoint;
    logic            confirmed;
    logic            fine_mode;
    logic            display_update;
  } result_t;

  typedef struct packed {
    logic                    prev_a;
    logic                    prev_b;
    logic signed [CNT_W-1:0] pulse_count;
    logic [SP_W-1:0]         current_setpoint;
    logic [SP_W-1:0]         original_setpoint;
    logic                    is_confirmed;
    logic                    fine_selected;
    logic [ADJ_W-1:0]        since_adjust;
    logic [UPD_W-1:0]        since_update;
  } state_t;

endpackage

`default_nettype wire

@@ sv/esa_in_if.sv @@
// ----------------------------------------------------------------------------
// esa_in_if
// Input channel: one tick of sampled encoder pins and qualified pulses.
// ----------------------------------------------------------------------------
`default_nettype none

interface esa_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic confirm_pulse;
  logic reset_pulse;
  logic toggle_pulse;

  modport source (
    output valid, pin_a, pin_b, confirm_pulse, reset_pulse, toggle_pulse,
    input  ready
  );

  modport sink (
    input  valid, pin_a, pin_b, confirm_pulse, reset_pulse, toggle_pulse,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/esa_out_if.sv @@
// ----------------------------------------------------------------------------
// esa_out_if
// Result channel: setpoint and status word for each tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface esa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] setpoint;
  logic        confirmed;
  logic        fine_mode;
  logic        display_update;

  modport source (
    output valid, setpoint, confirmed, fine_mode, display_update,
    input  ready
  );

  modport sink (
    input  valid, setpoint, confirmed, fine_mode, display_update,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/esa_cfg.sv @@
// ----------------------------------------------------------------------------
// esa_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [esa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [esa_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  output esa_pkg::cfg_t                         cfg,
  output logic                                  sp_load
);

  esa_pkg::cfg_t cfg_r;
  esa_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    sp_load = 1'b0;
    if (cfg_we) begin
      unique case (esa_pkg::reg_idx_t'(cfg_idx))
        esa_pkg::REG_INITIAL_SETPOINT: sp_load = 1'b1;
        esa_pkg::REG_SETPOINT_MIN:     cfg_nxt.setpoint_min = cfg_wdata;
        esa_pkg::REG_SETPOINT_MAX:     cfg_nxt.setpoint_max = cfg_wdata;
        esa_pkg::REG_FINE_STEP: begin
          cfg_nxt.fine_step = cfg_wdata[esa_pkg::STEP_W-1:0];
        end
        esa_pkg::REG_COARSE_STEP: begin
          cfg_nxt.coarse_step = cfg_wdata[esa_pkg::STEP_W-1:0];
        end
        esa_pkg::REG_CONFIRM_TIMEOUT:  cfg_nxt.confirm_timeout_ticks = cfg_wdata;
        esa_pkg::REG_UPDATE_INTERVAL: begin
          cfg_nxt.update_interval_ticks = cfg_wdata[esa_pkg::INTV_W-1:0];
        end
        esa_pkg::REG_REVERSE_DIR:      cfg_nxt.reverse_direction = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_min          <= esa_pkg::SP_MIN_RST;
      cfg_r.setpoint_max          <= esa_pkg::SP_MAX_RST;
      cfg_r.fine_step             <= esa_pkg::FINE_RST;
      cfg_r.coarse_step           <= esa_pkg::COARSE_RST;
      cfg_r.confirm_timeout_ticks <= esa_pkg::TIMEOUT_RST;
      cfg_r.update_interval_ticks <= esa_pkg::INTERVAL_RST;
      cfg_r.reverse_direction     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ sv/esa_step.sv @@
// ----------------------------------------------------------------------------
// esa_step
// Per-tick update rule: edge decode, pulse count, scaled and clamped
// setpoint change, mode toggle, confirm, reset and timeout rollback.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_step (
  input  wire esa_pkg::cfg_t   cfg,
  input  wire esa_pkg::state_t st,
  input  wire esa_pkg::item_t  item,
  output esa_pkg::state_t      st_nxt,
  output esa_pkg::result_t     res
);

  logic [esa_pkg::ADJ_W-1:0]        sa_inc;
  logic [esa_pkg::UPD_W-1:0]        su_inc;
  logic                             eff_a;
  logic                             eff_b;
  logic                             eff_pa;
  logic                             eff_pb;
  logic                             dec;
  logic                             inc;
  logic signed [esa_pkg::CNT_W-1:0] cnt_edge;
  logic                             apply;
  logic [esa_pkg::STEP_W-1:0]       step;
  logic signed [esa_pkg::PROD_W-1:0] prod;
  logic signed [esa_pkg::SUM_W-1:0]  sum;
  logic signed [esa_pkg::SUM_W-1:0]  hi;
  logic signed [esa_pkg::SUM_W-1:0]  lo;
  logic signed [esa_pkg::SUM_W-1:0]  clamp_hi;
  logic signed [esa_pkg::SUM_W-1:0]  clamp_lo;
  logic                             disp;

  assign sa_inc = (st.since_adjust == '1) ? st.since_adjust
                                          : st.since_adjust + esa_pkg::ADJ_W'(1);
  assign su_inc = (st.since_update == '1) ? st.since_update
                                          : st.since_update + esa_pkg::UPD_W'(1);

  assign eff_a  = cfg.reverse_direction ? item.pin_b : item.pin_a;
  assign eff_b  = cfg.reverse_direction ? item.pin_a : item.pin_b;
  assign eff_pa = cfg.reverse_direction ? st.prev_b : st.prev_a;
  assign eff_pb = cfg.reverse_direction ? st.prev_a : st.prev_b;
  assign dec    = eff_a & ~eff_pa & ~eff_b;
  assign inc    = eff_b & ~eff_pb & ~eff_a;

  always_comb begin
    priority if (dec && st.pulse_count != esa_pkg::CNT_MIN) begin
      cnt_edge = st.pulse_count - esa_pkg::CNT_W'(1);
    end else if (inc && st.pulse_count != esa_pkg::CNT_MAX) begin
      cnt_edge = st.pulse_count + esa_pkg::CNT_W'(1);
    end else begin
      cnt_edge = st.pulse_count;
    end
  end

  assign apply = (su_inc >= cfg.update_interval_ticks) && (cnt_edge != '0);
  assign step  = st.fine_selected ? cfg.fine_step : cfg.coarse_step;

  assign prod = esa_pkg::PROD_W'(cnt_edge) * esa_pkg::PROD_W'($signed({1'b0, step}));
  assign sum  = esa_pkg::SUM_W'($signed({1'b0, st.current_setpoint})) +
                esa_pkg::SUM_W'(prod);
  assign hi   = esa_pkg::SUM_W'($signed({1'b0, cfg.setpoint_max}));
  assign lo   = esa_pkg::SUM_W'($signed({1'b0, cfg.setpoint_min}));

  assign clamp_hi = (sum > hi) ? hi : sum;
  assign clamp_lo = (clamp_hi < lo) ? lo : clamp_hi;

  always_comb begin
    st_nxt              = st;
    st_nxt.prev_a       = item.pin_a;
    st_nxt.prev_b       = item.pin_b;
    st_nxt.pulse_count  = cnt_edge;
    st_nxt.since_adjust = sa_inc;
    st_nxt.since_update = su_inc;
    disp                = 1'b0;

    if (apply) begin
      if (st.is_confirmed) begin
        st_nxt.original_setpoint = st.current_setpoint;
      end
      st_nxt.is_confirmed     = 1'b0;
      st_nxt.current_setpoint = clamp_lo[esa_pkg::SP_W-1:0];
      st_nxt.pulse_count      = '0;
      st_nxt.since_update     = '0;
      st_nxt.since_adjust     = '0;
      disp                    = 1'b1;
    end
    if (item.toggle_pulse) begin
      st_nxt.fine_selected = ~st.fine_selected;
      disp                 = 1'b1;
    end
    if (item.confirm_pulse && !st_nxt.is_confirmed) begin
      st_nxt.is_confirmed = 1'b1;
      disp                = 1'b1;
    end
    if (item.reset_pulse) begin
      st_nxt.current_setpoint = st_nxt.original_setpoint;
      st_nxt.is_confirmed     = 1'b1;
      disp                    = 1'b1;
    end
    if (!st_nxt.is_confirmed &&
        (st_nxt.since_adjust > esa_pkg::ADJ_W'(cfg.confirm_timeout_ticks))) begin
      st_nxt.current_setpoint = st_nxt.original_setpoint;
      st_nxt.is_confirmed     = 1'b1;
      disp                    = 1'b1;
    end
  end

  assign res.setpoint       = st_nxt.current_setpoint;
  assign res.confirmed      = st_nxt.is_confirmed;
  assign res.fine_mode      = st_nxt.fine_selected;
  assign res.display_update = disp;

endmodule

`default_nettype wire

@@ sv/encoder_setpoint_adjuster.sv @@
// ----------------------------------------------------------------------------
// encoder_setpoint_adjuster
// Turns quadrature encoder ticks and button pulses into a clamped setpoint
// with confirmation, reset and timeout rollback.
//
// Each word on in_if is one tick: encoder pins A and B plus confirm, reset
// and toggle pulses. Each accepted word yields exactly one word on out_if
// with the setpoint, the confirmed and fine-mode flags, and a display
// update flag. Configuration is written through cfg_we, cfg_idx and
// cfg_wdata only while the block is idle; the user must keep to this, as the
// block does not enforce it. A write of the initial setpoint also loads the
// current and original setpoints. A word is registered on entry and its
// result on exit; the result is offered once the word moves from the input
// to the output register. One word is taken every cycle while out_if.ready
// allows; the update of the adjuster state sets that rate. Reset restores
// configuration and adjuster state to defaults and empties both stages.
// When the receiver stalls, the output word holds, the input register takes
// one more word, and then in_if.ready falls until out_if.ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_setpoint_adjuster (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  esa_in_if.sink                             in_if,
  esa_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [esa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [esa_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  esa_pkg::cfg_t    cfg;
  logic             sp_load;
  logic             s1_valid_r;
  esa_pkg::item_t   s1_item_r;
  esa_pkg::state_t  st_r;
  esa_pkg::state_t  st_nxt;
  esa_pkg::result_t res;
  logic             out_valid_r;
  esa_pkg::result_t out_res_r;
  logic             advance;
  logic             in_ready;

  esa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .sp_load   (sp_load)
  );

  esa_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_ready    = !s1_valid_r || advance;
  assign in_if.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      s1_item_r.pin_a         <= in_if.pin_a;
      s1_item_r.pin_b         <= in_if.pin_b;
      s1_item_r.confirm_pulse <= in_if.confirm_pulse;
      s1_item_r.reset_pulse   <= in_if.reset_pulse;
      s1_item_r.toggle_pulse  <= in_if.toggle_pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.prev_a            <= 1'b0;
      st_r.prev_b            <= 1'b0;
      st_r.pulse_count       <= '0;
      st_r.current_setpoint  <= esa_pkg::INIT_SP_RST;
      st_r.original_setpoint <= esa_pkg::INIT_SP_RST;
      st_r.is_confirmed      <= 1'b1;
      st_r.fine_selected     <= 1'b1;
      st_r.since_adjust      <= '0;
      st_r.since_update      <= '0;
    end else if (sp_load) begin
      st_r.current_setpoint  <= cfg_wdata;
      st_r.original_setpoint <= cfg_wdata;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.setpoint       = out_res_r.setpoint;
  assign out_if.confirmed      = out_res_r.confirmed;
  assign out_if.fine_mode      = out_res_r.fine_mode;
  assign out_if.display_update = out_res_r.display_update;

endmodule

`default_nettype wire

@@ sv/esa_checker.sv @@
// ----------------------------------------------------------------------------
// esa_checker
// Port-level checks on the encoder setpoint adjuster, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_setpoint,
  input wire logic        out_confirmed,
  input wire logic        out_fine_mode,
  input wire logic        out_display_update
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_setpoint) &&
      $stable(out_confirmed) && $stable(out_fine_mode) &&
      $stable(out_display_update))
    else $error("esa: stalled result word changed");

  // An accepted word is always followed by a valid output, holding it or an older result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("esa: no result two cycles after acceptance");

  // A new result only ever follows an accepted word.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("esa: result without an accepted word");

  // With the output register empty, the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("esa: input stalled with empty output");

endmodule

bind encoder_setpoint_adjuster esa_checker u_esa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_setpoint       (out_if.setpoint),
  .out_confirmed      (out_if.confirmed),
  .out_fine_mode      (out_if.fine_mode),
  .out_display_update (out_if.display_update)
);

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the encoder setpoint adjuster.
//
// A queue of encoder ticks feeds a clocked driver on the input channel. A
// clocked monitor on the result channel checks every word against a
// prediction. The prediction is made when a tick is accepted and is held in
// order of arrival. The run covers hand-picked corner cases and
// well-formed quadrature bursts with random button presses. It also includes
// noise, idle stretches and a long one-direction spin that drives the pulse
// count into saturation. Both channels idle at several rates, and one long
// hold on the result side backs the block up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [esa_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [esa_pkg::CFG_DAT_W-1:0] cfg_wdata;

  esa_in_if  in_if ();
  esa_out_if out_if ();

  encoder_setpoint_adjuster dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  esa_pkg::item_t   tick_queue[$];
  esa_pkg::result_t setpoint_words_due[$];
  esa_pkg::item_t   on_bus;
  int               send_idle_pct;
  int               recv_stall_pct;
  logic             hold_req;
  int               hold_left;
  int               err_count;
  int               word_count;
  int               cycle_count;

  logic [esa_pkg::SP_W-1:0]   r_min;
  logic [esa_pkg::SP_W-1:0]   r_max;
  logic [esa_pkg::STEP_W-1:0] r_fine;
  logic [esa_pkg::STEP_W-1:0] r_coarse;
  logic [esa_pkg::TMO_W-1:0]  r_timeout;
  logic [esa_pkg::INTV_W-1:0] r_interval;
  logic                       r_reverse;

  logic                             last_a;
  logic                             last_b;
  logic signed [esa_pkg::CNT_W-1:0] pulses;
  logic [esa_pkg::SP_W-1:0]         sp_now;
  logic [esa_pkg::SP_W-1:0]         sp_saved;
  logic                             sp_confirmed;
  logic                             fine_sel;
  logic [esa_pkg::ADJ_W-1:0]        adj_age;
  logic [esa_pkg::UPD_W-1:0]        upd_age;

  logic [4:0] opening_ticks [0:12] = '{
    5'b00000, 5'b10000, 5'b00000, 5'b00100, 5'b00001, 5'b01000, 5'b01100,
    5'b11000, 5'b01000, 5'b00000, 5'b10010, 5'b11111, 5'b00011
  };
  logic [4:0] clamp_ticks [0:2] = '{5'b00000, 5'b01000, 5'b10000};
  logic [4:0] reversed_ticks [0:5] = '{
    5'b10000, 5'b00000, 5'b01000, 5'b00000, 5'b10000, 5'b00100
  };

  function automatic esa_pkg::result_t advance_setpoint(esa_pkg::item_t tk);
    logic                       a;
    logic                       b;
    logic                       pa;
    logic                       pb;
    logic [esa_pkg::STEP_W-1:0] step;
    int                         nv;
    esa_pkg::result_t           r;
    r.display_update = 1'b0;
    if (adj_age != '1) adj_age = adj_age + esa_pkg::ADJ_W'(1);
    if (upd_age != '1) upd_age = upd_age + esa_pkg::UPD_W'(1);
    if (r_reverse) begin
      a = tk.pin_b; b = tk.pin_a; pa = last_b; pb = last_a;
    end else begin
      a = tk.pin_a; b = tk.pin_b; pa = last_a; pb = last_b;
    end
    if (a && !pa && !b && pulses != esa_pkg::CNT_MIN) pulses = pulses - esa_pkg::CNT_W'(1);
    if (b && !pb && !a && pulses != esa_pkg::CNT_MAX) pulses = pulses + esa_pkg::CNT_W'(1);
    last_a = tk.pin_a;
    last_b = tk.pin_b;
    if (upd_age >= r_interval && pulses != 0) begin
      step = fine_sel ? r_fine : r_coarse;
      if (sp_confirmed) begin
        sp_saved = sp_now;
        sp_confirmed = 1'b0;
      end
      nv = int'(sp_now) + int'(pulses) * int'(step);
      if (nv > int'(r_max)) nv = int'(r_max);
      if (nv < int'(r_min)) nv = int'(r_min);
      sp_now = nv[esa_pkg::SP_W-1:0];
      pulses = '0;
      upd_age = '0;
      adj_age = '0;
      r.display_update = 1'b1;
    end
    if (tk.toggle_pulse) begin
      fine_sel = !fine_sel;
      r.display_update = 1'b1;
    end
    if (tk.confirm_pulse && !sp_confirmed) begin
      sp_confirmed = 1'b1;
      r.display_update = 1'b1;
    end
    if (tk.reset_pulse) begin
      sp_now = sp_saved;
      sp_confirmed = 1'b1;
      r.display_update = 1'b1;
    end
    if (!sp_confirmed && adj_age > esa_pkg::ADJ_W'(r_timeout)) begin
      sp_now = sp_saved;
      sp_confirmed = 1'b1;
      r.display_update = 1'b1;
    end
    r.setpoint = sp_now;
    r.confirmed = sp_confirmed;
    r.fine_mode = fine_sel;
    return r;
  endfunction

  function automatic esa_pkg::item_t with_buttons(logic a, logic b);
    esa_pkg::item_t tk;
    tk.pin_a = a;
    tk.pin_b = b;
    tk.confirm_pulse = ($urandom_range(0, 11) == 0);
    tk.reset_pulse = ($urandom_range(0, 29) == 0);
    tk.toggle_pulse = ($urandom_range(0, 14) == 0);
    return tk;
  endfunction

  task automatic queue_ticks(int n);
    int         made;
    int         kind;
    int         reps;
    logic [7:0] pattern;
    logic [1:0] ab;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        pattern = $urandom_range(0, 1) ? 8'b00_10_11_01 : 8'b00_01_11_10;
        reps = $urandom_range(1, 5);
        for (int d = 0; d < reps * 4; d++) begin
          ab = pattern[7 - 2 * (d % 4) -: 2];
          tick_queue.push_back(with_buttons(ab[1], ab[0]));
          made++;
        end
      end else if (kind < 85) begin
        tick_queue.push_back(with_buttons(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        made++;
      end else begin
        reps = $urandom_range(1, 70);
        repeat (reps) begin
          tick_queue.push_back(with_buttons(1'b0, 1'b0));
          made++;
        end
      end
    end
  endtask

  task automatic cfg_write(esa_pkg::reg_idx_t idx, logic [esa_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      esa_pkg::REG_INITIAL_SETPOINT: begin
        sp_now = val;
        sp_saved = val;
      end
      esa_pkg::REG_SETPOINT_MIN:    r_min = val;
      esa_pkg::REG_SETPOINT_MAX:    r_max = val;
      esa_pkg::REG_FINE_STEP:       r_fine = val[esa_pkg::STEP_W-1:0];
      esa_pkg::REG_COARSE_STEP:     r_coarse = val[esa_pkg::STEP_W-1:0];
      esa_pkg::REG_CONFIRM_TIMEOUT: r_timeout = val;
      esa_pkg::REG_UPDATE_INTERVAL: r_interval = val[esa_pkg::INTV_W-1:0];
      esa_pkg::REG_REVERSE_DIR:     r_reverse = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    while (tick_queue.size() != 0 || setpoint_words_due.size() != 0 || in_if.valid) begin
      @(negedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_ticks
    esa_pkg::item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.pin_a <= 1'b0;
      in_if.pin_b <= 1'b0;
      in_if.confirm_pulse <= 1'b0;
      in_if.reset_pulse <= 1'b0;
      in_if.toggle_pulse <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        setpoint_words_due.push_back(advance_setpoint(on_bus));
      end
      if (!in_if.valid || in_if.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = tick_queue.pop_front();
          on_bus = nxt;
          in_if.valid <= 1'b1;
          in_if.pin_a <= nxt.pin_a;
          in_if.pin_b <= nxt.pin_b;
          in_if.confirm_pulse <= nxt.confirm_pulse;
          in_if.reset_pulse <= nxt.reset_pulse;
          in_if.toggle_pulse <= nxt.toggle_pulse;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    esa_pkg::result_t got;
    esa_pkg::result_t want;
    string            bad;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.setpoint = out_if.setpoint;
      got.confirmed = out_if.confirmed;
      got.fine_mode = out_if.fine_mode;
      got.display_update = out_if.display_update;
      word_count++;
      if (setpoint_words_due.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("word %0d: unexpected word, setpoint %0d", word_count, got.setpoint);
        end
      end else begin
        want = setpoint_words_due.pop_front();
        bad = "";
        if (got.setpoint !== want.setpoint) bad = {bad, " setpoint"};
        if (got.confirmed !== want.confirmed) bad = {bad, " confirmed"};
        if (got.fine_mode !== want.fine_mode) bad = {bad, " fine_mode"};
        if (got.display_update !== want.display_update) bad = {bad, " display_update"};
        if (bad != "") begin
          err_count++;
          if (err_count <= 10) begin
            $display("word %0d mismatch in%s: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                     word_count, bad, want.setpoint, want.confirmed, want.fine_mode,
                     want.display_update, got.setpoint, got.confirmed, got.fine_mode,
                     got.display_update);
          end
        end
      end
    end
  end

  initial begin : run_phases
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    r_min = esa_pkg::SP_MIN_RST;
    r_max = esa_pkg::SP_MAX_RST;
    r_fine = esa_pkg::FINE_RST;
    r_coarse = esa_pkg::COARSE_RST;
    r_timeout = esa_pkg::TIMEOUT_RST;
    r_interval = esa_pkg::INTERVAL_RST;
    r_reverse = 1'b0;
    last_a = 1'b0;
    last_b = 1'b0;
    pulses = '0;
    sp_now = esa_pkg::INIT_SP_RST;
    sp_saved = esa_pkg::INIT_SP_RST;
    sp_confirmed = 1'b1;
    fine_sel = 1'b1;
    adj_age = '0;
    upd_age = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_ticks(15);
    drain();

    // Zero interval and zero timeout, then min above max, then a direction
    // swap while pin A is still high.
    cfg_write(esa_pkg::REG_INITIAL_SETPOINT, 16'd800);
    cfg_write(esa_pkg::REG_UPDATE_INTERVAL, 16'd0);
    cfg_write(esa_pkg::REG_CONFIRM_TIMEOUT, 16'd0);
    cfg_write(esa_pkg::REG_FINE_STEP, 16'd1);
    cfg_write(esa_pkg::REG_COARSE_STEP, 16'd10000);
    foreach (opening_ticks[i]) tick_queue.push_back(esa_pkg::item_t'(opening_ticks[i]));
    drain();
    cfg_write(esa_pkg::REG_SETPOINT_MIN, 16'd1000);
    cfg_write(esa_pkg::REG_SETPOINT_MAX, 16'd600);
    foreach (clamp_ticks[i]) tick_queue.push_back(esa_pkg::item_t'(clamp_ticks[i]));
    drain();
    cfg_write(esa_pkg::REG_REVERSE_DIR, 16'd1);
    foreach (reversed_ticks[i]) tick_queue.push_back(esa_pkg::item_t'(reversed_ticks[i]));
    drain();

    cfg_write(esa_pkg::REG_REVERSE_DIR, 16'd0);
    cfg_write(esa_pkg::REG_INITIAL_SETPOINT, 16'd0);
    cfg_write(esa_pkg::REG_SETPOINT_MIN, 16'd0);
    cfg_write(esa_pkg::REG_SETPOINT_MAX, 16'hFFFF);
    cfg_write(esa_pkg::REG_FINE_STEP, 16'd10000);
    cfg_write(esa_pkg::REG_COARSE_STEP, 16'd3);
    cfg_write(esa_pkg::REG_CONFIRM_TIMEOUT, 16'd40);
    cfg_write(esa_pkg::REG_UPDATE_INTERVAL, 16'd2);
    queue_ticks(80);
    drain();

    // The short interval makes the last change land on a tick with both pins
    // low, so the long spin below starts a fresh window with its first pulse.
    send_idle_pct = 58;
    cfg_write(esa_pkg::REG_INITIAL_SETPOINT, 16'hFFFF);
    cfg_write(esa_pkg::REG_SETPOINT_MIN, 16'd100);
    cfg_write(esa_pkg::REG_FINE_STEP, 16'd0);
    cfg_write(esa_pkg::REG_COARSE_STEP, 16'd7);
    cfg_write(esa_pkg::REG_CONFIRM_TIMEOUT, 16'hFFFF);
    cfg_write(esa_pkg::REG_UPDATE_INTERVAL, 16'd3);
    repeat (6) tick_queue.push_back(esa_pkg::item_t'(5'b00000));
    repeat (2) begin
      tick_queue.push_back(esa_pkg::item_t'(5'b01000));
      tick_queue.push_back(esa_pkg::item_t'(5'b00000));
    end
    drain();
    cfg_write(esa_pkg::REG_UPDATE_INTERVAL, 16'd255);
    repeat (128) begin
      tick_queue.push_back(with_buttons(1'b0, 1'b1));
      tick_queue.push_back(with_buttons(1'b0, 1'b0));
    end
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 58;
    cfg_write(esa_pkg::REG_INITIAL_SETPOINT, 16'd1234);
    cfg_write(esa_pkg::REG_SETPOINT_MIN, 16'd200);
    cfg_write(esa_pkg::REG_SETPOINT_MAX, 16'd1500);
    cfg_write(esa_pkg::REG_FINE_STEP, 16'd10);
    cfg_write(esa_pkg::REG_COARSE_STEP, 16'd100);
    cfg_write(esa_pkg::REG_CONFIRM_TIMEOUT, 16'd15);
    cfg_write(esa_pkg::REG_UPDATE_INTERVAL, 16'd1);
    queue_ticks(80);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    drain();

    send_idle_pct = 30;
    recv_stall_pct = 30;
    cfg_write(esa_pkg::REG_REVERSE_DIR, 16'd1);
    cfg_write(esa_pkg::REG_INITIAL_SETPOINT, 16'd300);
    cfg_write(esa_pkg::REG_SETPOINT_MIN, 16'd250);
    cfg_write(esa_pkg::REG_SETPOINT_MAX, 16'd20000);
    cfg_write(esa_pkg::REG_FINE_STEP, 16'd25);
    cfg_write(esa_pkg::REG_COARSE_STEP, 16'd1000);
    cfg_write(esa_pkg::REG_CONFIRM_TIMEOUT, 16'd60);
    cfg_write(esa_pkg::REG_UPDATE_INTERVAL, 16'd8);
    queue_ticks(80);
    drain();

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/esa_pkg.sv
sv/esa_in_if.sv
sv/esa_out_if.sv
sv/esa_cfg.sv
sv/esa_step.sv
sv/encoder_setpoint_adjuster.sv
sv/esa_checker.sv
test/tb.sv
